// File: rtl/infix_expression_evaluator_core_defines.svh
// Assertion macros used by the evaluator core.
`ifndef INFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define IEE_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define IEE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/iee_pkg.sv
package iee_pkg;

  localparam int unsigned StackDepth = 32;
  localparam int unsigned StackAw    = $clog2(StackDepth);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);
  localparam int unsigned VarCount   = 26;

  typedef enum logic [2:0] {
    REQ_NUM   = 3'd0,
    REQ_VAR   = 3'd1,
    REQ_OPEN  = 3'd2,
    REQ_CLOSE = 3'd3,
    REQ_OP    = 3'd4,
    REQ_END   = 3'd5
  } req_e;

  localparam logic [2:0] OpPow   = 3'd0;
  localparam logic [2:0] OpMul   = 3'd1;
  localparam logic [2:0] OpDiv   = 3'd2;
  localparam logic [2:0] OpMod   = 3'd3;
  localparam logic [2:0] OpAdd   = 3'd4;
  localparam logic [2:0] OpSub   = 3'd5;
  localparam logic [2:0] OpParen = 3'd6;

  localparam logic [1:0] ErrNone  = 2'd0;
  localparam logic [1:0] ErrDiv0  = 2'd1;
  localparam logic [1:0] ErrOver  = 2'd2;
  localparam logic [1:0] ErrUnder = 2'd3;

  // Datapath commands.
  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_PUSH_LIT = 4'd1,
    CMD_PUSH_VAR = 4'd2,
    CMD_PUSH_OPR = 4'd3,  // push operator (op field)
    CMD_POP_OPR  = 4'd4,  // drop top operator
    CMD_RD_OPR   = 4'd5,  // fetch top operator
    CMD_RD_B     = 4'd6,  // pop right operand
    CMD_RD_A     = 4'd7,  // pop left operand
    CMD_ALU      = 4'd8,  // start arithmetic unit
    CMD_PUSH_RES = 4'd9,
    CMD_RD_TOP   = 4'd10, // fetch top operand for end
    CMD_FINISH   = 4'd11, // capture result, clear expression state
    CMD_ERR      = 4'd12, // record error code
    CMD_END_TOK  = 4'd13  // capture store target of the end token
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [2:0]  op;
    logic [1:0]  err;
  } dp_cmd_t;

  typedef struct packed {
    logic [CountW-1:0] opd_cnt;
    logic [CountW-1:0] opr_cnt;
    logic [2:0]        top_op;   // valid after CMD_RD_OPR
    logic [1:0]        err;
    logic              alu_done;
    logic              div_zero;
  } dp_sts_t;

  function automatic logic [2:0] prec(input logic [2:0] op);
    logic [2:0] p;
    if (op == OpPow) p = 3'd5;
    else if (op <= OpMod) p = 3'd4;
    else p = 3'd2;
    return p;
  endfunction

endpackage

// File: rtl/infix_expression_evaluator_core.sv
// Infix expression evaluator: takes one token per transfer and evaluates with an operand
// stack and an operator stack (power right-associative, precedence ^ > * / % > + -).
// A number, variable or open-paren token is pushed directly; an operator or close paren
// first performs each reduction it triggers. / and % use a bit-serial divider and ^
// uses square-and-multiply (one multiply per cycle in the shared
// arithmetic unit). An end token reduces the rest and returns result_value and
// error_code; errors are sticky within an expression. The 26 variables clear at reset.
module infix_expression_evaluator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic signed [31:0] literal_value_i,
  input  logic [4:0]  var_index_i,
  input  logic [2:0]  op_code_i,
  input  logic        store_enable_i,
  input  logic [4:0]  store_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]  error_code_o
);
  import iee_pkg::*;
`include "infix_expression_evaluator_core_defines.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;

  iee_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .op_code_i   (op_code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  iee_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .literal_value_i (literal_value_i),
    .var_index_i     (var_index_i),
    .store_enable_i  (store_enable_i),
    .store_index_i   (store_index_i),
    .sts_o           (sts),
    .result_value_o  (result_value_o),
    .error_code_o    (error_code_o)
  );

  `IEE_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, (sts.opd_cnt <= CountW'(StackDepth)) && (sts.opr_cnt <= CountW'(StackDepth)), "stack count beyond depth")
  `IEE_ASSERT_NEXT(a_finish_clears, clk_i, rst_ni, cmd.cmd == CMD_FINISH, sts.opd_cnt == '0 && sts.err == ErrNone && out_valid_o, "end did not clear state")
  `IEE_ASSERT_IMPL(a_err_result_zero, clk_i, rst_ni, out_valid_o && error_code_o != ErrNone, result_value_o == 32'd0, "errored result not zero")
endmodule

// File: rtl/iee_alu.sv
module iee_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);
  import iee_pkg::*;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_POW  = 4'b0010,
    A_DIV  = 4'b0100,
    A_MUL  = 4'b1000
  } alu_e;

  alu_e        state_q, state_d;
  logic [31:0] r_q, r_d, x_q, x_d, e_q, e_d;
  logic [31:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic        neg_q, neg_d, rneg_q, rneg_d, mod_q, mod_d;
  logic [31:0] res_q, res_d;
  logic [31:0] abs_a, abs_b, dvs_q, dvs_d;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] prod_rx, prod_xx, prod_ab;

  assign abs_a   = a_i[31] ? (~a_i + 32'd1) : a_i;
  assign abs_b   = b_i[31] ? (~b_i + 32'd1) : b_i;
  assign rem_sh  = {rem_q[30:0], x_q[31]};
  assign trial   = {1'b0, rem_sh} - {1'b0, dvs_q};
  assign prod_rx = r_q * x_q;
  assign prod_xx = x_q * x_q;
  assign prod_ab = a_i * b_i;

  always_comb begin
    state_d = state_q;
    r_d = r_q; x_d = x_q; e_d = e_q; rem_d = rem_q; cnt_d = cnt_q;
    neg_d = neg_q; rneg_d = rneg_q; mod_d = mod_q; dvs_d = dvs_q;
    res_d = res_q;
    done_d = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (start_i) begin
          case (op_i)
            OpPow: begin
              if (b_i[31]) begin
                done_d = 1'b1;
                if (a_i == 32'd1) res_d = 32'd1;
                else if (a_i == 32'hFFFF_FFFF) res_d = b_i[0] ? 32'hFFFF_FFFF : 32'd1;
                else res_d = 32'd0;
              end else begin
                r_d = 32'd1; x_d = a_i; e_d = b_i;
                state_d = A_POW;
              end
            end
            OpMul: begin
              res_d = prod_ab;
              done_d = 1'b1;
            end
            OpDiv, OpMod: begin
              x_d = abs_a; dvs_d = abs_b; rem_d = '0; cnt_d = 6'd32;
              neg_d = a_i[31] ^ b_i[31]; rneg_d = a_i[31];
              mod_d = (op_i == OpMod);
              state_d = A_DIV;
            end
            OpAdd: begin
              res_d = a_i + b_i;
              done_d = 1'b1;
            end
            default: begin
              res_d = a_i - b_i;
              done_d = 1'b1;
            end
          endcase
        end
      end
      A_POW: begin
        // one multiply per cycle: first update r, then square x
        if (e_q == 32'd0) begin
          res_d = r_q;
          done_d = 1'b1;
          state_d = A_IDLE;
        end else begin
          if (e_q[0]) r_d = prod_rx;
          state_d = A_MUL;
        end
      end
      A_MUL: begin
        x_d = prod_xx;
        e_d = {1'b0, e_q[31:1]};
        state_d = A_POW;
      end
      A_DIV: begin
        if (!trial[32]) begin
          rem_d = trial[31:0];
          x_d = {x_q[30:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          x_d = {x_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
    // return to idle if a division step is reached with the count at zero
    if (state_q == A_DIV && cnt_q == 6'd0) begin
      state_d = A_IDLE;
    end
  end

  // Sign fixup after the last division step.
  logic div_fin_q;
  logic [31:0] fix;
  always_comb begin
    if (mod_q) fix = rneg_q ? (~rem_q + 32'd1) : rem_q;
    else fix = neg_q ? (~x_q + 32'd1) : x_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= A_IDLE;
      done_q    <= 1'b0;
      div_fin_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d | div_fin_q;
      div_fin_q <= (state_q == A_DIV) && (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; x_q <= x_d; e_q <= e_d; rem_q <= rem_d; cnt_q <= cnt_d;
    neg_q <= neg_d; rneg_q <= rneg_d; mod_q <= mod_d; dvs_q <= dvs_d;
    res_q <= div_fin_q ? fix : res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

// File: rtl/iee_datapath.sv
module iee_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iee_pkg::dp_cmd_t     cmd_i,
  input  logic [31:0]          literal_value_i,
  input  logic [4:0]           var_index_i,
  input  logic                 store_enable_i,
  input  logic [4:0]           store_index_i,
  output iee_pkg::dp_sts_t     sts_o,
  output logic [31:0]          result_value_o,
  output logic [1:0]           error_code_o
);
  import iee_pkg::*;

  logic [31:0] opd_mem [StackDepth];
  logic [2:0]  opr_mem [StackDepth];
  logic [31:0] var_q   [VarCount];

  logic [CountW-1:0] opd_cnt_q, opr_cnt_q;
  logic [1:0]        err_q;
  logic [31:0]       opd_rd_q, a_q, b_q, var_rd;
  logic [2:0]        opr_rd_q;
  logic              wr_en;
  logic [31:0]       wr_data;
  logic [StackAw-1:0] wr_addr, opd_raddr, opr_raddr;
  logic              alu_done;
  logic [31:0]       alu_res;
  logic              rd_b_q;
  logic              store_en_q;
  logic [4:0]        store_idx_q;

  assign var_rd = (var_index_i < 5'(VarCount)) ? var_q[var_index_i] : 32'd0;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = literal_value_i;
    case (cmd_i.cmd)
      CMD_PUSH_LIT: wr_en = 1'b1;
      CMD_PUSH_VAR: begin
        wr_en = 1'b1;
        wr_data = var_rd;
      end
      CMD_PUSH_RES: begin
        wr_en = 1'b1;
        wr_data = alu_res;
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign wr_addr   = opd_cnt_q[StackAw-1:0];
  assign opd_raddr = StackAw'(opd_cnt_q - CountW'(1));
  assign opr_raddr = StackAw'(opr_cnt_q - CountW'(1));

  always_ff @(posedge clk_i) begin
    if (wr_en) opd_mem[wr_addr] <= wr_data;
    opd_rd_q <= opd_mem[opd_raddr];
    if (cmd_i.cmd == CMD_PUSH_OPR) opr_mem[opr_cnt_q[StackAw-1:0]] <= cmd_i.op;
    opr_rd_q <= opr_mem[opr_raddr];
  end

  // Registered operand read data is captured into b_q after a CMD_RD_B and into a_q otherwise.
  always_ff @(posedge clk_i) begin
    if (rd_b_q) b_q <= opd_rd_q;
    else a_q <= opd_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opd_cnt_q <= '0;
      opr_cnt_q <= '0;
      err_q     <= ErrNone;
      rd_b_q    <= 1'b0;
      store_en_q  <= 1'b0;
      store_idx_q <= '0;
      result_value_o <= '0;
      error_code_o   <= ErrNone;
      for (int i = 0; i < VarCount; i++) var_q[i] <= '0;
    end else begin
      rd_b_q <= (cmd_i.cmd == CMD_RD_B);
      case (cmd_i.cmd)
        CMD_PUSH_LIT, CMD_PUSH_VAR, CMD_PUSH_RES: opd_cnt_q <= opd_cnt_q + CountW'(1);
        CMD_PUSH_OPR: opr_cnt_q <= opr_cnt_q + CountW'(1);
        CMD_POP_OPR:  opr_cnt_q <= opr_cnt_q - CountW'(1);
        CMD_RD_B, CMD_RD_A: opd_cnt_q <= opd_cnt_q - CountW'(1);
        CMD_ERR: if (err_q == ErrNone) err_q <= cmd_i.err;
        CMD_END_TOK: begin
          store_en_q  <= store_enable_i;
          store_idx_q <= store_index_i;
        end
        CMD_FINISH: begin
          error_code_o   <= err_q;
          result_value_o <= (err_q == ErrNone) ? opd_rd_q : 32'd0;
          if (err_q == ErrNone && store_en_q && store_idx_q < 5'(VarCount))
            var_q[store_idx_q] <= opd_rd_q;
          opd_cnt_q <= '0;
          opr_cnt_q <= '0;
          err_q     <= ErrNone;
        end
        default: ;
      endcase
    end
  end

  iee_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cmd == CMD_ALU),
    .op_i    (cmd_i.op),
    .a_i     (a_q),
    .b_i     (b_q),
    .done_o  (alu_done),
    .res_o   (alu_res)
  );

  assign sts_o.opd_cnt  = opd_cnt_q;
  assign sts_o.opr_cnt  = opr_cnt_q;
  assign sts_o.top_op   = opr_rd_q;
  assign sts_o.err      = err_q;
  assign sts_o.alu_done = alu_done;
  assign sts_o.div_zero = (b_q == 32'd0);
endmodule

// File: rtl/iee_ctrl.sv
module iee_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        req_type_i,
  input  logic [2:0]        op_code_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  iee_pkg::dp_sts_t  sts_i,
  output iee_pkg::dp_cmd_t  cmd_o
);
  import iee_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LOOP   = 11'b00000000010, // decide next reduction step
    S_TOPW   = 11'b00000000100, // wait for top operator read
    S_TOPC   = 11'b00000001000, // check top operator
    S_RDB    = 11'b00000010000,
    S_RDA    = 11'b00000100000,
    S_ALUGO  = 11'b00001000000,
    S_ALUW   = 11'b00010000000,
    S_ENDW   = 11'b00100000000,
    S_ENDF   = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } ctl_e;

  ctl_e       state_q, state_d;
  logic [2:0] type_q, type_d, op_q, op_d, red_q, red_d;
  logic       out_v_q, out_v_d;
  logic       stop;

  always_comb begin
    state_d = state_q;
    type_d = type_q; op_d = op_q; red_d = red_q;
    out_v_d = out_v_q;
    cmd_o.cmd = CMD_NONE;
    cmd_o.op  = op_q;
    cmd_o.err = ErrNone;
    stop = 1'b0;
    if (out_v_q && !out_stall_i) out_v_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          type_d = req_type_i;
          op_d   = op_code_i;
          if (req_type_i == REQ_END) begin
            cmd_o.cmd = CMD_END_TOK;
            state_d = S_LOOP;
          end else if (sts_i.err != ErrNone) state_d = S_IDLE;
          else begin
            case (req_type_i)
              REQ_NUM, REQ_VAR: begin
                if (sts_i.opd_cnt >= CountW'(StackDepth)) begin
                  cmd_o.cmd = CMD_ERR; cmd_o.err = ErrOver;
                end else cmd_o.cmd = (req_type_i == REQ_NUM) ? CMD_PUSH_LIT : CMD_PUSH_VAR;
              end
              REQ_OPEN: begin
                if (sts_i.opr_cnt >= CountW'(StackDepth)) begin
                  cmd_o.cmd = CMD_ERR; cmd_o.err = ErrOver;
                end else begin
                  cmd_o.cmd = CMD_PUSH_OPR; cmd_o.op = OpParen;
                end
              end
              REQ_CLOSE: state_d = S_LOOP;
              REQ_OP: if (op_code_i <= OpSub) state_d = S_LOOP;
              default: state_d = S_IDLE;
            endcase
          end
        end
      end
      S_LOOP: begin
        if (sts_i.err != ErrNone || sts_i.opr_cnt == '0) stop = 1'b1;
        else begin
          cmd_o.cmd = CMD_RD_OPR;
          state_d = S_TOPW;
        end
        if (stop) begin
          if (type_q == REQ_END) begin
            if (sts_i.err == ErrNone && sts_i.opd_cnt == '0) begin
              cmd_o.cmd = CMD_ERR; cmd_o.err = ErrUnder;
            end
            state_d = S_ENDW;
          end else if (type_q == REQ_OP && sts_i.err == ErrNone) begin
            if (sts_i.opr_cnt >= CountW'(StackDepth)) begin
              cmd_o.cmd = CMD_ERR; cmd_o.err = ErrOver;
            end else cmd_o.cmd = CMD_PUSH_OPR;
            state_d = S_IDLE;
          end else state_d = S_IDLE;
        end
      end
      S_TOPW: state_d = S_TOPC;
      S_TOPC: begin
        red_d = sts_i.top_op;
        state_d = S_IDLE;
        if (sts_i.top_op == OpParen) begin
          if (type_q == REQ_END) begin
            cmd_o.cmd = CMD_POP_OPR; state_d = S_LOOP;
          end else if (type_q == REQ_CLOSE) cmd_o.cmd = CMD_POP_OPR;
          else if (type_q == REQ_OP) begin
            cmd_o.cmd = CMD_PUSH_OPR;
            if (sts_i.opr_cnt >= CountW'(StackDepth)) begin
              cmd_o.cmd = CMD_ERR; cmd_o.err = ErrOver;
            end
          end
        end else if (type_q == REQ_OP &&
                     (op_q == OpPow || prec(sts_i.top_op) < prec(op_q))) begin
          cmd_o.cmd = CMD_PUSH_OPR;
          if (sts_i.opr_cnt >= CountW'(StackDepth)) begin
            cmd_o.cmd = CMD_ERR; cmd_o.err = ErrOver;
          end
        end else begin
          // reduce: operator is popped regardless of operand count
          cmd_o.cmd = CMD_POP_OPR;
          state_d = S_RDB;
        end
      end
      S_RDB: begin
        if (sts_i.opd_cnt < CountW'(2)) begin
          cmd_o.cmd = CMD_ERR; cmd_o.err = ErrUnder;
          state_d = S_LOOP;
        end else begin
          cmd_o.cmd = CMD_RD_B;
          state_d = S_RDA;
        end
      end
      S_RDA: begin
        cmd_o.cmd = CMD_RD_A;
        state_d = S_ALUGO;
      end
      S_ALUGO: begin
        // a lands this cycle edge; start next cycle
        state_d = S_ALUW;
      end
      S_ALUW: begin
        cmd_o.op = red_q;
        if (red_q != OpPow && red_q != OpMul && red_q != OpAdd && red_q != OpSub &&
            sts_i.div_zero) begin
          cmd_o.cmd = CMD_ERR; cmd_o.err = ErrDiv0;
          state_d = S_LOOP;
        end else begin
          cmd_o.cmd = CMD_ALU;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.op = red_q;
        if (sts_i.alu_done) begin
          cmd_o.cmd = CMD_PUSH_RES; // count below depth after popping two
          state_d = S_LOOP;
        end
      end
      S_ENDW: begin
        cmd_o.cmd = CMD_RD_TOP;
        state_d = S_ENDF;
      end
      S_ENDF: begin
        // hold until the previous result has been taken
        if (!out_v_q || !out_stall_i) begin
          cmd_o.cmd = CMD_FINISH;
          out_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    op_q   <= op_d;
    red_q  <= red_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_v_q;
endmodule

// File: test/infix_expression_evaluator_core_tb.sv
module infix_expression_evaluator_core_tb;
  import iee_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] lit;
    logic [4:0]  vidx;
    logic [2:0]  op;
    logic        sen;
    logic [4:0]  sidx;
  } token_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  err;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  req_type_i;
  logic [31:0] literal_value_i;
  logic [4:0]  var_index_i;
  logic [2:0]  op_code_i;
  logic        store_enable_i;
  logic [4:0]  store_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] result_value_o;
  logic [1:0]  error_code_o;

  infix_expression_evaluator_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .literal_value_i,
    .var_index_i, .op_code_i, .store_enable_i, .store_index_i, .out_valid_o,
    .out_stall_i, .result_value_o, .error_code_o
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Predictor state.
  logic [31:0] opd_stk [StackDepth];
  int unsigned opd_cnt;
  logic [2:0]  opr_stk [StackDepth];
  int unsigned opr_cnt;
  logic [31:0] vars [VarCount];
  logic [1:0]  err_q;

  token_t   pending_tokens[$];
  outcome_t expected_results[$];
  int       errors = 0;
  int       results_seen = 0;
  int       tokens_sent = 0;
  int       err_seen [4];
  bit       stimulus_done = 0;
  bit       long_hold = 0;
  longint   cycle_count = 0;

  function automatic void flag(logic [1:0] code);
    if (err_q == ErrNone) err_q = code;
  endfunction

  function automatic logic [2:0] rank(logic [2:0] op);
    if (op == OpPow) return 3'd5;
    if (op <= OpMod) return 3'd4;
    return 3'd2;
  endfunction

  function automatic void push_opd(logic [31:0] v);
    if (opd_cnt >= StackDepth) begin
      flag(ErrOver);
      return;
    end
    opd_stk[opd_cnt] = v;
    opd_cnt++;
  endfunction

  function automatic void push_opr(logic [2:0] op);
    if (opr_cnt >= StackDepth) begin
      flag(ErrOver);
      return;
    end
    opr_stk[opr_cnt] = op;
    opr_cnt++;
  endfunction

  function automatic logic [31:0] int_pow(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    r = 32'd1;
    if (b[31]) begin
      if (a == 32'd1) return 32'd1;
      if (a == 32'hFFFF_FFFF) return b[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    while (b != 0) begin
      if (b[0]) r = r * a;
      a = a * a;
      b = b >> 1;
    end
    return r;
  endfunction

  function automatic void apply_top();
    logic [2:0]  op;
    logic [31:0] a, b, r;
    opr_cnt--;
    op = opr_stk[opr_cnt];
    if (opd_cnt < 2) begin
      flag(ErrUnder);
      return;
    end
    opd_cnt--;
    b = opd_stk[opd_cnt];
    opd_cnt--;
    a = opd_stk[opd_cnt];
    case (op)
      OpPow: r = int_pow(a, b);
      OpMul: r = a * b;
      OpDiv, OpMod: begin
        if (b == 0) begin
          flag(ErrDiv0);
          return;
        end
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r = (op == OpDiv) ? a : 32'd0;
        else if (op == OpDiv) r = $signed(a) / $signed(b);
        else r = $signed(a) % $signed(b);
      end
      OpAdd: r = a + b;
      default: r = a - b;
    endcase
    push_opd(r);
  endfunction

  function automatic void evaluate_token(token_t t);
    outcome_t o;
    if (t.kind == REQ_END) begin
      o.value = '0;
      while (err_q == ErrNone && opr_cnt > 0) begin
        if (opr_stk[opr_cnt-1] == OpParen) opr_cnt--;
        else apply_top();
      end
      if (err_q == ErrNone && opd_cnt == 0) flag(ErrUnder);
      if (err_q == ErrNone) begin
        o.value = opd_stk[opd_cnt-1];
        if (t.sen && t.sidx < VarCount) vars[t.sidx] = o.value;
      end
      o.err = err_q;
      expected_results.push_back(o);
      opd_cnt = 0;
      opr_cnt = 0;
      err_q = ErrNone;
      return;
    end
    if (err_q != ErrNone) return;
    case (t.kind)
      REQ_NUM: push_opd(t.lit);
      REQ_VAR: push_opd(t.vidx < VarCount ? vars[t.vidx] : 32'd0);
      REQ_OPEN: push_opr(OpParen);
      REQ_CLOSE: begin
        while (err_q == ErrNone && opr_cnt > 0 && opr_stk[opr_cnt-1] != OpParen)
          apply_top();
        if (err_q == ErrNone && opr_cnt > 0) opr_cnt--;
      end
      REQ_OP: begin
        if (t.op <= OpSub) begin
          if (t.op != OpPow)
            while (err_q == ErrNone && opr_cnt > 0 && opr_stk[opr_cnt-1] != OpParen &&
                   rank(opr_stk[opr_cnt-1]) >= rank(t.op))
              apply_top();
          if (err_q == ErrNone) push_opr(t.op);
        end
      end
      default: ;
    endcase
  endfunction

  // Stimulus construction.
  function automatic token_t tok(logic [2:0] kind, logic [31:0] lit = 0, logic [2:0] op = 0);
    token_t t;
    t.kind = kind;
    t.lit = lit;
    t.vidx = 5'($urandom_range(0, 31));
    t.op = op;
    t.sen = 1'($urandom_range(0, 1));
    t.sidx = 5'($urandom_range(0, 31));
    return t;
  endfunction

  function automatic logic [31:0] rand_lit();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'hFFFF_FFFF;
      4: return 32'd0;
      default: return $urandom_range(0, 9);
    endcase
  endfunction

  function automatic void add_operand();
    token_t t;
    if ($urandom_range(0, 3) == 0) begin
      t = tok(REQ_VAR);
      if ($urandom_range(0, 7) != 0) t.vidx = 5'($urandom_range(0, VarCount - 1));
    end else begin
      t = tok(REQ_NUM, rand_lit());
    end
    pending_tokens.push_back(t);
  endfunction

  // Well-formed expression of random shape, nesting bounded by depth.
  function automatic void add_expr(int depth);
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i <= n; i++) begin
      if (i > 0) pending_tokens.push_back(tok(REQ_OP, 0, 3'($urandom_range(0, 5))));
      if (depth > 0 && $urandom_range(0, 3) == 0) begin
        pending_tokens.push_back(tok(REQ_OPEN));
        add_expr(depth - 1);
        pending_tokens.push_back(tok(REQ_CLOSE));
      end else begin
        add_operand();
      end
    end
  endfunction

  function automatic void add_end();
    pending_tokens.push_back(tok(REQ_END));
  endfunction

  function automatic void add_binary(logic [31:0] a, logic [2:0] op, logic [31:0] b);
    pending_tokens.push_back(tok(REQ_NUM, a));
    pending_tokens.push_back(tok(REQ_OP, 0, op));
    pending_tokens.push_back(tok(REQ_NUM, b));
    add_end();
  endfunction

  initial begin
    token_t t;
    int     k;
    for (int i = 0; i < VarCount; i++) vars[i] = '0;
    opd_cnt = 0;
    opr_cnt = 0;
    err_q = ErrNone;
    // Directed: each operator and the corner cases.
    add_binary(32'h8000_0000, OpDiv, 32'hFFFF_FFFF);
    add_binary(32'h8000_0000, OpMod, 32'hFFFF_FFFF);
    add_binary(32'd7, OpDiv, 32'd0);
    add_binary(32'hFFFF_FFF9, OpMod, 32'd2);
    add_binary(32'd0, OpPow, 32'd0);
    add_binary(32'hFFFF_FFFF, OpPow, 32'hFFFF_FFFB);
    add_binary(32'd3, OpPow, 32'h7FFF_FFFF);
    add_binary(32'h7FFF_FFFF, OpMul, 32'h7FFF_FFFF);
    add_binary(32'h7FFF_FFFF, OpAdd, 32'd1);
    add_binary(32'h8000_0000, OpSub, 32'd1);
    pending_tokens.push_back(tok(REQ_CLOSE));
    add_end();
    t = tok(REQ_OP, 0, OpAdd); pending_tokens.push_back(t); add_end();
    // Stores and reads of variables, including an out-of-range index.
    t = tok(REQ_NUM, 32'd42); pending_tokens.push_back(t);
    t = tok(REQ_END); t.sen = 1; t.sidx = 25; pending_tokens.push_back(t);
    t = tok(REQ_VAR); t.vidx = 25; pending_tokens.push_back(t);
    t = tok(REQ_END); t.sen = 1; t.sidx = 31; pending_tokens.push_back(t);
    // Overflow on both stacks.
    for (int i = 0; i < StackDepth + 2; i++) add_operand();
    add_end();
    for (int i = 0; i < StackDepth + 2; i++) pending_tokens.push_back(tok(REQ_OPEN));
    add_end();
    t = tok(REQ_OP, 0, 3'd6); pending_tokens.push_back(t);
    t = tok(3'd7); pending_tokens.push_back(t);
    add_end();
    // Random part: mostly well-formed, some noise.
    while (pending_tokens.size() < 1350) begin
      k = $urandom_range(0, 9);
      if (k < 8) begin
        add_expr(3);
      end else begin
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          t = tok(3'($urandom_range(0, 7)), rand_lit(), 3'($urandom_range(0, 7)));
          if (t.kind != REQ_END) pending_tokens.push_back(t);
        end
      end
      add_end();
    end
  end

  // Driver.
  int send_gap = 0;
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    req_type_i = '0;
    literal_value_i = '0;
    var_index_i = '0;
    op_code_i = '0;
    store_enable_i = 1'b0;
    store_index_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        evaluate_token(pending_tokens.pop_front());
        tokens_sent++;
        send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_tokens.size() > 0) begin
          in_valid_i <= 1'b1;
          req_type_i <= pending_tokens[0].kind;
          literal_value_i <= pending_tokens[0].lit;
          var_index_i <= pending_tokens[0].vidx;
          op_code_i <= pending_tokens[0].op;
          store_enable_i <= pending_tokens[0].sen;
          store_index_i <= pending_tokens[0].sidx;
        end else begin
          in_valid_i <= 1'b0;
          stimulus_done = 1;
        end
      end
    end
  end

  // Monitor and receiver stall.
  int hold_left = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value=%h err=%0d", $time, result_value_o,
                   error_code_o);
          errors++;
        end else begin
          outcome_t e;
          e = expected_results.pop_front();
          err_seen[e.err]++;
          if (result_value_o !== e.value || error_code_o !== e.err) begin
            $display("%0t: mismatch expected value=%h err=%0d actual value=%h err=%0d",
                     $time, e.value, e.err, result_value_o, error_code_o);
            errors++;
          end
        end
        hold_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      end
      // Hold off once for a long stretch mid-run so the input backs up.
      if (!long_hold && tokens_sent > 300) begin
        long_hold = 1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int tail;
    tail = 0;
    fork
      begin
        wait (stimulus_done && expected_results.size() == 0);
        while (tail < 400) begin
          @(posedge clk_i);
          tail++;
        end
        $display("Run covered %0d tokens, %0d results (ok %0d, div0 %0d, over %0d, under %0d)",
                 tokens_sent, results_seen, err_seen[0], err_seen[1], err_seen[2],
                 err_seen[3]);
        if (errors == 0) $display("PASS infix_expression_evaluator_core");
        else $display("FAIL infix_expression_evaluator_core");
        $finish;
      end
      begin
        wait (cycle_count >= 2000000);
        $display("Timeout after %0d cycles", cycle_count);
        $display("FAIL infix_expression_evaluator_core");
        $finish;
      end
    join
  end
endmodule
